### hw/rtl/gbn_fec_pkg.sv
// ----------------------------------------------------------------------------
// gbn_fec_pkg
// Shared widths, codes and types for the Go-Back-N / XOR FEC receiver control.
// ----------------------------------------------------------------------------
package gbn_fec_pkg;

    localparam int OFS_W      = 31;
    localparam int PAY_W      = 16;
    localparam int WIN_W      = 8;
    localparam int SPAN_W     = PAY_W + WIN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int DIV_CNT_W  = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(OFS_W);

    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE   = 2'd2;

    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_FEC    = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [PAY_W-1:0]  PAY_RESET  = 16'd1024;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 8'd4;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 24'd4096;

    typedef enum logic [1:0] {
        DIV_IDLE = 2'b01,
        DIV_RUN  = 2'b10
    } div_state_t;

    typedef struct packed {
        logic              busy;
        logic [PAY_W-1:0]  payload;
        logic [OFS_W-1:0]  image;
        logic [SPAN_W-1:0] span;
        logic [OFS_W-1:0]  last_start;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [OFS_W-1:0]  seq;
        logic signed [OFS_W:0] fec_limit;
        logic [OFS_W-1:0]  base;
    } item_t;

    typedef struct packed {
        logic              ack_valid;
        logic              ack_is_finish;
        logic [OFS_W-1:0]  ack_offset;
        logic              recover;
        logic [OFS_W-1:0]  lost_at;
        logic [PAY_W-1:0]  lost_length;
        logic [OFS_W-1:0]  window_base;
        logic              in_go_back;
    } result_t;

endpackage

### hw/rtl/gbn_fec_in_if.sv
// ----------------------------------------------------------------------------
// gbn_fec_in_if
// Packet header channel: valid/ready with op and byte offset.
// ----------------------------------------------------------------------------
interface gbn_fec_in_if;
    import gbn_fec_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       op;
    logic [OFS_W-1:0] seq_offset;

    modport source (output valid, output op, output seq_offset, input ready);
    modport sink   (input valid, input op, input seq_offset, output ready);
endinterface

### hw/rtl/gbn_fec_out_if.sv
// ----------------------------------------------------------------------------
// gbn_fec_out_if
// Decision channel: valid/ready with ack and recover fields.
// ----------------------------------------------------------------------------
interface gbn_fec_out_if;
    import gbn_fec_pkg::*;

    logic             valid;
    logic             ready;
    logic             ack_valid;
    logic             ack_is_finish;
    logic [OFS_W-1:0] ack_offset;
    logic             recover;
    logic [OFS_W-1:0] lost_at;
    logic [PAY_W-1:0] lost_length;
    logic [OFS_W-1:0] window_base;
    logic             in_go_back;

    modport source (output valid, output ack_valid, output ack_is_finish,
                    output ack_offset, output recover, output lost_at,
                    output lost_length, output window_base, output in_go_back,
                    input ready);
    modport sink   (input valid, input ack_valid, input ack_is_finish,
                    input ack_offset, input recover, input lost_at,
                    input lost_length, input window_base, input in_go_back,
                    output ready);
endinterface

### hw/rtl/gbn_fec_cfg.sv
// ----------------------------------------------------------------------------
// gbn_fec_cfg
// Configuration registers and derived values: window span (D*W) and start of
// the last segment (floor(I/D)*D) from a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module gbn_fec_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [gbn_fec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbn_fec_pkg::CFG_DATA_W-1:0]  cfg_data,
    output gbn_fec_pkg::cfg_t                   cfg
);
    import gbn_fec_pkg::*;

    logic [PAY_W-1:0]     pay_reg;
    logic [WIN_W-1:0]     win_reg;
    logic [OFS_W-1:0]     image_reg;
    logic [SPAN_W-1:0]    span_reg;
    logic [OFS_W-1:0]     last_reg;
    div_state_t           div_state_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [PAY_W-1:0]     rem_reg;
    logic [PAY_W-1:0]     rem_next;
    logic [PAY_W:0]       rem_shift;
    logic [DIV_CNT_W-1:0] bit_idx;

    assign bit_idx   = cnt_reg - DIV_CNT_W'(1);
    assign rem_shift = {rem_reg, image_reg[bit_idx]};

    always_comb
    begin
        if (rem_shift >= {1'b0, pay_reg})
        begin
            rem_next = PAY_W'(rem_shift - {1'b0, pay_reg});
        end
        else
        begin
            rem_next = rem_shift[PAY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pay_reg   <= PAY_RESET;
            win_reg   <= WIN_RESET;
            image_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PAYLOAD: pay_reg   <= cfg_data[PAY_W-1:0];
                REG_WINDOW:  win_reg   <= cfg_data[WIN_W-1:0];
                REG_IMAGE:   image_reg <= cfg_data[OFS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= SPAN_RESET;
        end
        else
        begin
            span_reg <= SPAN_W'(pay_reg * win_reg);
        end
    end

    // restart the divider on every write; one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_state_reg <= DIV_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            last_reg      <= '0;
        end
        else if (cfg_write)
        begin
            div_state_reg <= DIV_RUN;
            cnt_reg       <= DIV_STEPS;
            rem_reg       <= '0;
        end
        else
        begin
            case (div_state_reg)
                DIV_RUN:
                begin
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                    if (cnt_reg == DIV_CNT_W'(1))
                    begin
                        div_state_reg <= DIV_IDLE;
                        if (pay_reg == '0)
                        begin
                            last_reg <= '0;
                        end
                        else
                        begin
                            last_reg <= image_reg - {{(OFS_W-PAY_W){1'b0}}, rem_next};
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign cfg.busy       = (div_state_reg == DIV_RUN);
    assign cfg.payload    = pay_reg;
    assign cfg.image      = image_reg;
    assign cfg.span       = span_reg;
    assign cfg.last_start = last_reg;

endmodule

### hw/rtl/gbn_fec_front.sv
// ----------------------------------------------------------------------------
// gbn_fec_front
// Header intake: accept a beat and precompute the state-free terms (FEC loss
// limit, window base) before the item enters the queue.
// ----------------------------------------------------------------------------
module gbn_fec_front
(
    gbn_fec_in_if.sink          in_ch,
    input  gbn_fec_pkg::cfg_t   cfg,
    input  logic                q_full,
    output logic                push,
    output gbn_fec_pkg::item_t  push_item
);
    import gbn_fec_pkg::*;

    logic signed [OFS_W:0] seq_minus_pay;
    logic                  past_end;

    assign in_ch.ready = !cfg.busy && !q_full;
    assign push        = in_ch.valid && in_ch.ready;

    assign seq_minus_pay = signed'({1'b0, in_ch.seq_offset})
                         - signed'({{(OFS_W+1-PAY_W){1'b0}}, cfg.payload});
    assign past_end      = (in_ch.seq_offset >= cfg.image);

    always_comb
    begin
        push_item.op  = in_ch.op;
        push_item.seq = in_ch.seq_offset;
        if (past_end)
        begin
            push_item.fec_limit = signed'({1'b0, cfg.last_start});
        end
        else
        begin
            push_item.fec_limit = seq_minus_pay;
        end
        push_item.base = in_ch.seq_offset - {{(OFS_W-SPAN_W){1'b0}}, cfg.span};
    end

endmodule

### hw/rtl/gbn_fec_queue.sv
// ----------------------------------------------------------------------------
// gbn_fec_queue
// Two-entry item queue between the front and the back.
// ----------------------------------------------------------------------------
module gbn_fec_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gbn_fec_pkg::item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output gbn_fec_pkg::item_t  head_item
);
    import gbn_fec_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### hw/rtl/gbn_fec_back.sv
// ----------------------------------------------------------------------------
// gbn_fec_back
// Receiver state update and decision register: expected offset, loss, window
// start and go-back mode, one item per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module gbn_fec_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  gbn_fec_pkg::cfg_t   cfg,
    input  logic                q_not_empty,
    input  gbn_fec_pkg::item_t  item,
    output logic                pop,
    gbn_fec_out_if.source       out_ch
);
    import gbn_fec_pkg::*;

    logic [OFS_W-1:0] exp_reg, exp_next;
    logic             lp_reg, lp_next;
    logic [OFS_W-1:0] lo_reg, lo_next;
    logic [OFS_W-1:0] ws_reg, ws_next;
    logic             gb_reg, gb_next;
    logic             out_valid_reg;
    result_t          res_reg, res_next;

    logic [OFS_W-1:0]      pay_ext;
    logic [OFS_W-1:0]      exp_plus1;
    logic [OFS_W-1:0]      exp_plus2;
    logic signed [OFS_W:0] exp_s;
    logic signed [OFS_W:0] win_diff;
    logic                  overrun;
    logic                  fec_one;
    logic                  fec_more;
    logic [OFS_W-1:0]      lo_eff;
    logic [OFS_W:0]        lo_end;
    logic [OFS_W-1:0]      img_left;

    assign pop = q_not_empty && (!out_valid_reg || out_ch.ready);

    assign pay_ext   = {{(OFS_W-PAY_W){1'b0}}, cfg.payload};
    assign exp_plus1 = exp_reg + pay_ext;
    assign exp_plus2 = exp_reg + {pay_ext[OFS_W-2:0], 1'b0};
    assign exp_s     = signed'({1'b0, exp_reg});
    assign win_diff  = signed'({1'b0, item.seq}) - signed'({1'b0, ws_reg});
    assign overrun   = win_diff >= signed'({{(OFS_W+1-SPAN_W){1'b0}}, cfg.span});
    assign fec_one   = exp_s <= item.fec_limit;
    assign fec_more  = exp_s < item.fec_limit;
    assign lo_eff    = lp_reg ? lo_reg : exp_reg;
    assign lo_end    = {1'b0, lo_eff} + {1'b0, pay_ext};
    assign img_left  = cfg.image - lo_eff;

    always_comb
    begin
        exp_next = exp_reg;
        lp_next  = lp_reg;
        lo_next  = lo_reg;
        ws_next  = ws_reg;
        gb_next  = gb_reg;
        res_next = '0;
        case (item.op)
            OP_DATA:
            begin
                if (item.seq < exp_reg)
                begin
                    if (lp_reg && (item.seq == lo_reg))
                    begin
                        lp_next = 1'b0;
                    end
                    if (!lp_next && !gb_reg)
                    begin
                        res_next.ack_valid  = 1'b1;
                        res_next.ack_offset = exp_reg;
                    end
                end
                else if (item.seq == exp_reg)
                begin
                    exp_next = exp_plus1;
                    gb_next  = 1'b0;
                    if (!lp_reg)
                    begin
                        res_next.ack_valid  = 1'b1;
                        res_next.ack_offset = exp_plus1;
                    end
                end
                else if (!lp_reg && !gb_reg)
                begin
                    lo_next = exp_reg;
                    lp_next = 1'b1;
                    if (item.seq == exp_plus1)
                    begin
                        exp_next = exp_plus2;
                        gb_next  = (item.seq > exp_plus2);
                    end
                    else
                    begin
                        exp_next = exp_plus1;
                        gb_next  = (item.seq > exp_plus1);
                    end
                end
                else
                begin
                    gb_next = 1'b1;
                end
                // window overrun: slide the window, or fall back to the loss
                if (overrun && !gb_next)
                begin
                    if (!lp_next)
                    begin
                        ws_next = exp_next;
                    end
                    else
                    begin
                        exp_next = lo_next;
                        lp_next  = 1'b0;
                        gb_next  = 1'b1;
                    end
                end
            end
            OP_FEC:
            begin
                if (!gb_reg)
                begin
                    if (!lp_reg && fec_more)
                    begin
                        lp_next  = 1'b1;
                        lo_next  = exp_reg;
                        gb_next  = 1'b1;
                        exp_next = exp_plus1;
                    end
                    else
                    begin
                        if ((lp_reg || fec_one))
                        begin
                            res_next.recover     = 1'b1;
                            res_next.lost_at     = lo_eff;
                            res_next.window_base = item.base;
                            if (lo_end >= {1'b0, cfg.image})
                            begin
                                if (lo_eff > cfg.image)
                                begin
                                    res_next.lost_length = '0;
                                end
                                else
                                begin
                                    res_next.lost_length = img_left[PAY_W-1:0];
                                end
                            end
                            else
                            begin
                                res_next.lost_length = cfg.payload;
                            end
                        end
                        if (!lp_reg && fec_one)
                        begin
                            lo_next = exp_reg;
                        end
                        lp_next             = 1'b0;
                        ws_next             = item.seq;
                        exp_next            = item.seq;
                        res_next.ack_valid  = 1'b1;
                        res_next.ack_offset = item.seq;
                    end
                end
            end
            OP_FINISH:
            begin
                res_next.ack_valid     = 1'b1;
                res_next.ack_is_finish = 1'b1;
            end
            default: ;
        endcase
        res_next.in_go_back = gb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg       <= '0;
            lp_reg        <= 1'b0;
            lo_reg        <= '0;
            ws_reg        <= '0;
            gb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            exp_reg       <= exp_next;
            lp_reg        <= lp_next;
            lo_reg        <= lo_next;
            ws_reg        <= ws_next;
            gb_reg        <= gb_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.ack_valid     = res_reg.ack_valid;
    assign out_ch.ack_is_finish = res_reg.ack_is_finish;
    assign out_ch.ack_offset    = res_reg.ack_offset;
    assign out_ch.recover       = res_reg.recover;
    assign out_ch.lost_at       = res_reg.lost_at;
    assign out_ch.lost_length   = res_reg.lost_length;
    assign out_ch.window_base   = res_reg.window_base;
    assign out_ch.in_go_back    = res_reg.in_go_back;

endmodule

### hw/rtl/gbn_fec_receiver_control_unit.sv
// ----------------------------------------------------------------------------
// gbn_fec_receiver_control_unit
// Go-Back-N receiver control with XOR FEC loss recovery decisions.
//
//   channel   dir   handshake      beat
//   in_ch     in    valid/ready    op, seq_offset
//   out_ch    out   valid/ready    ack, recover and go-back fields
//   cfg       in    write enable   cfg_index, cfg_data
//
// One beat per cycle unless a configuration write or an output stall holds
// intake; a header is queued, and the back stage's state update registers
// its decision. A two-entry queue and the output register let each side
// stall on its own. Every configuration write holds in_ch.ready low while
// the serial divider derives the last-segment start (one bit per cycle).
// Reset is asynchronous, active low, and clears all receiver state.
// ----------------------------------------------------------------------------
module gbn_fec_receiver_control_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [gbn_fec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbn_fec_pkg::CFG_DATA_W-1:0]  cfg_data,
    gbn_fec_in_if.sink                          in_ch,
    gbn_fec_out_if.source                       out_ch
);
    import gbn_fec_pkg::*;

    cfg_t  cfg;
    logic  push;
    item_t push_item;
    logic  q_full;
    logic  q_pop;
    logic  q_not_empty;
    item_t head_item;

    gbn_fec_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gbn_fec_front u_front
    (
        .in_ch     (in_ch),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    gbn_fec_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    gbn_fec_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .item        (head_item),
        .pop         (q_pop),
        .out_ch      (out_ch)
    );

endmodule

### hw/rtl/gbn_fec_checker.sv
// ----------------------------------------------------------------------------
// gbn_fec_checker
// Port-level checks on the receiver control: output beat protocol, decision
// field consistency and intake hold-off after configuration writes.
// ----------------------------------------------------------------------------
module gbn_fec_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_write,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic                             ack_valid,
    input logic                             ack_is_finish,
    input logic [gbn_fec_pkg::OFS_W-1:0]    ack_offset,
    input logic                             recover,
    input logic [gbn_fec_pkg::OFS_W-1:0]    lost_at,
    input logic [gbn_fec_pkg::PAY_W-1:0]    lost_length,
    input logic [gbn_fec_pkg::OFS_W-1:0]    window_base,
    input logic                             in_go_back
);
    import gbn_fec_pkg::*;

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ack_offset) && $stable(lost_at)
            && $stable(recover) && $stable(in_go_back))
        else $error("output beat dropped or changed while stalled");

    a_cfg_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !in_ready)
        else $error("header accepted while derived values are stale");

    a_finish_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ack_is_finish |-> ack_valid && ack_offset == '0 && !recover)
        else $error("finish ack malformed");

    a_recover_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && recover |-> ack_valid && !ack_is_finish && !in_go_back)
        else $error("recover without fresh ack");

    a_recover_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !recover |-> lost_at == '0 && lost_length == '0
            && window_base == '0)
        else $error("recover fields set without recover");

endmodule

bind gbn_fec_receiver_control_unit gbn_fec_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write     (cfg_write),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .ack_valid     (out_ch.ack_valid),
    .ack_is_finish (out_ch.ack_is_finish),
    .ack_offset    (out_ch.ack_offset),
    .recover       (out_ch.recover),
    .lost_at       (out_ch.lost_at),
    .lost_length   (out_ch.lost_length),
    .window_base   (out_ch.window_base),
    .in_go_back    (out_ch.in_go_back)
);
